FILE: design/dmw_pkg.sv
package dmw_pkg;

  // Fixed field widths.
  localparam int PIX_W      = 32;
  localparam int POS_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int STEP_W     = 9;
  localparam int GREY_W     = 8;
  localparam int DISP_W     = 17;
  localparam int SUB_W      = 8;
  localparam int CRD_W      = 10;
  localparam int SUM_W      = 11;
  localparam int WT_W       = 9;
  localparam int PROD_W     = 17;
  localparam int ACC_W      = 18;
  localparam int CHANNELS   = 3;
  localparam int NEIGHBORS  = 4;
  localparam int NB_IDX_W   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXACT_MODE   = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_FRAME_SIZE = 10'd512;

  // Arithmetic constants.
  localparam int                GREY_SHIFT  = 2;
  localparam int                BLEND_SHIFT = 10;
  localparam logic [WT_W-1:0]   WT_FULL     = 9'd510;
  localparam logic [WT_W-1:0]   WT_HALF     = 9'd255;

  // Result queue.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_SKIP,
    OP_LOAD,
    OP_FAST,
    OP_EXACT,
    OP_BORDER
  } op_kind_e;

  // One decoded request on its way to the sequencer.
  typedef struct packed {
    op_kind_e                        kind;
    logic [NEIGHBORS-1:0][WT_W-1:0]  wt;
    logic [POS_W-1:0]                x;
    logic [POS_W-1:0]                y;
    logic [PIX_W-1:0]                data;
  } op_t;

  // Tag that travels alongside a memory access.
  typedef struct packed {
    logic              vld;
    logic              last;
    op_kind_e          kind;
    logic [NB_IDX_W-1:0] k;
    logic [WT_W-1:0]   wt;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } tag_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             unch;
  } res_t;

endpackage

FILE: design/dmw_in_if.sv
interface dmw_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [dmw_pkg::POS_W-1:0]  pos_x;
  logic [dmw_pkg::POS_W-1:0]  pos_y;
  logic [dmw_pkg::PIX_W-1:0]  pixel_data;

  modport source (output valid, func, pos_x, pos_y, pixel_data, input ready);
  modport sink (input valid, func, pos_x, pos_y, pixel_data, output ready);
endinterface

FILE: design/dmw_out_if.sv
interface dmw_out_if;
  logic                       valid;
  logic                       ready;
  logic [dmw_pkg::PIX_W-1:0]  out_pixel;
  logic [dmw_pkg::POS_W-1:0]  out_x;
  logic [dmw_pkg::POS_W-1:0]  out_y;
  logic                       unchanged;

  modport source (output valid, out_pixel, out_x, out_y, unchanged, input ready);
  modport sink (input valid, out_pixel, out_x, out_y, unchanged, output ready);
endinterface

FILE: design/dmw_cfg_if.sv
interface dmw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dmw_pkg::CFG_IDX_W-1:0]   index;
  logic [dmw_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/dmw_front.sv
module dmw_front #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  localparam int AddrW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dmw_in_if.sink                          req_i,
  input  logic [dmw_pkg::CRD_W-1:0]       wm1_i,
  input  logic [dmw_pkg::CRD_W-1:0]       hm1_i,
  input  logic signed [dmw_pkg::STEP_W-1:0] step_x_i,
  input  logic signed [dmw_pkg::STEP_W-1:0] step_y_i,
  input  logic                            exact_i,
  output logic                            op_valid_o,
  input  logic                            op_ready_i,
  output dmw_pkg::op_t                    op_o,
  output logic [AddrW-1:0]                addr_o [dmw_pkg::NEIGHBORS]
);

  // Stage 1: accepted request.
  logic                         s1_v_q;
  logic                         s1_func_q;
  logic [dmw_pkg::POS_W-1:0]    s1_x_q, s1_y_q;
  logic [dmw_pkg::PIX_W-1:0]    s1_data_q;
  // Stage 2: displacement.
  logic                         s2_v_q;
  logic                         s2_func_q;
  logic [dmw_pkg::POS_W-1:0]    s2_x_q, s2_y_q;
  logic [dmw_pkg::PIX_W-1:0]    s2_data_q;
  logic signed [dmw_pkg::DISP_W-1:0] s2_dx_q, s2_dy_q;
  // Stage 3: clamped neighbor coordinates.
  logic                         s3_v_q;
  dmw_pkg::op_t                 s3_op_q;
  logic [dmw_pkg::CRD_W-1:0]    s3_col0_q, s3_col1_q, s3_row0_q, s3_row1_q;

  logic s1_ready, s2_ready, s3_ready;

  logic [dmw_pkg::CRD_W-1:0]    grey_sum;
  logic [dmw_pkg::GREY_W-1:0]   grey;
  logic signed [dmw_pkg::DISP_W-1:0] dx_d, dy_d;

  logic signed [dmw_pkg::SUM_W-1:0] sum_x, sum_y;
  logic [dmw_pkg::CRD_W-1:0]    xn, yn, xr, yu;
  logic [dmw_pkg::SUB_W-1:0]    sx, sy;
  logic                         border, load_ok;
  dmw_pkg::op_t                 op_d;
  logic [dmw_pkg::CRD_W-1:0]    col0_d, col1_d, row0_d, row1_d;

  logic [AddrW-1:0]             base0, base1;

  assign s3_ready    = !s3_v_q || op_ready_i;
  assign s2_ready    = !s2_v_q || s3_ready;
  assign s1_ready    = !s1_v_q || s2_ready;
  assign req_i.ready = s1_ready;

  // Grey value and displacement in 1/256 pixel.
  always_comb begin
    grey_sum = {2'b00, req_i.pixel_data[7:0]} * 10'd0 + {2'b00, s1_data_q[7:0]}
             + {2'b00, s1_data_q[15:8]} + {2'b00, s1_data_q[23:16]};
    grey = dmw_pkg::GREY_W'(grey_sum >> dmw_pkg::GREY_SHIFT);
    dx_d = $signed({{(dmw_pkg::DISP_W-dmw_pkg::STEP_W){step_x_i[dmw_pkg::STEP_W-1]}}, step_x_i})
         * $signed({{(dmw_pkg::DISP_W-dmw_pkg::GREY_W){1'b0}}, grey});
    dy_d = $signed({{(dmw_pkg::DISP_W-dmw_pkg::STEP_W){step_y_i[dmw_pkg::STEP_W-1]}}, step_y_i})
         * $signed({{(dmw_pkg::DISP_W-dmw_pkg::GREY_W){1'b0}}, grey});
  end

  // Whole-pixel move, clamp to the frame, neighbors and weights.
  always_comb begin
    sum_x = $signed({2'b00, s2_x_q}) + $signed({{2{s2_dx_q[dmw_pkg::DISP_W-1]}},
                                                s2_dx_q[dmw_pkg::DISP_W-1:dmw_pkg::SUB_W]});
    sum_y = $signed({2'b00, s2_y_q}) + $signed({{2{s2_dy_q[dmw_pkg::DISP_W-1]}},
                                                s2_dy_q[dmw_pkg::DISP_W-1:dmw_pkg::SUB_W]});
    if (sum_x < 0) begin
      xn = '0;
    end else if (sum_x > $signed({1'b0, wm1_i})) begin
      xn = wm1_i;
    end else begin
      xn = sum_x[dmw_pkg::CRD_W-1:0];
    end
    if (sum_y < 0) begin
      yn = '0;
    end else if (sum_y > $signed({1'b0, hm1_i})) begin
      yn = hm1_i;
    end else begin
      yn = sum_y[dmw_pkg::CRD_W-1:0];
    end
    xr = (xn == wm1_i) ? xn : xn + 1'b1;
    yu = (yn == '0) ? yn : yn - 1'b1;
    sx = s2_dx_q[dmw_pkg::SUB_W-1:0];
    sy = s2_dy_q[dmw_pkg::SUB_W-1:0];

    border  = (s2_x_q == '0) || (s2_y_q == '0)
           || ({1'b0, s2_x_q} >= wm1_i) || ({1'b0, s2_y_q} >= hm1_i);
    load_ok = (32'(s2_x_q) < MAX_WIDTH) && (32'(s2_y_q) < MAX_HEIGHT);

    op_d.x     = s2_x_q;
    op_d.y     = s2_y_q;
    op_d.data  = s2_data_q;
    op_d.wt[0] = dmw_pkg::WT_FULL - {1'b0, sx} - {1'b0, sy};
    op_d.wt[1] = dmw_pkg::WT_HALF + {1'b0, sx} - {1'b0, sy};
    op_d.wt[2] = {1'b0, sx} + {1'b0, sy};
    op_d.wt[3] = dmw_pkg::WT_HALF + {1'b0, sy} - {1'b0, sx};

    col0_d = xn;
    col1_d = xr;
    row0_d = yn;
    row1_d = yu;
    if (!s2_func_q) begin
      op_d.kind = load_ok ? dmw_pkg::OP_LOAD : dmw_pkg::OP_SKIP;
      col0_d    = {1'b0, s2_x_q};
      row0_d    = {1'b0, s2_y_q};
    end else if (!exact_i) begin
      op_d.kind = dmw_pkg::OP_FAST;
    end else if (border) begin
      op_d.kind = dmw_pkg::OP_BORDER;
    end else begin
      op_d.kind = dmw_pkg::OP_EXACT;
    end
  end

  // Store addresses of the four neighbors; clamping keeps them in range.
  always_comb begin
    base0     = AddrW'(s3_row0_q) * AddrW'(MAX_WIDTH);
    base1     = AddrW'(s3_row1_q) * AddrW'(MAX_WIDTH);
    addr_o[0] = base0 + AddrW'(s3_col0_q);
    addr_o[1] = base0 + AddrW'(s3_col1_q);
    addr_o[2] = base1 + AddrW'(s3_col1_q);
    addr_o[3] = base1 + AddrW'(s3_col0_q);
  end

  assign op_valid_o = s3_v_q;
  assign op_o       = s3_op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= req_i.valid;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && req_i.valid) begin
      s1_func_q <= req_i.func;
      s1_x_q    <= req_i.pos_x;
      s1_y_q    <= req_i.pos_y;
      s1_data_q <= req_i.pixel_data;
    end
    if (s2_ready && s1_v_q) begin
      s2_func_q <= s1_func_q;
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_data_q <= s1_data_q;
      s2_dx_q   <= dx_d;
      s2_dy_q   <= dy_d;
    end
    if (s3_ready && s2_v_q) begin
      s3_op_q   <= op_d;
      s3_col0_q <= col0_d;
      s3_col1_q <= col1_d;
      s3_row0_q <= row0_d;
      s3_row1_q <= row1_d;
    end
  end

endmodule

FILE: design/dmw_frame_mem.sv
module dmw_frame_mem #(
  parameter int DEPTH = 262144,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            addr_i,
  input  logic [dmw_pkg::PIX_W-1:0]   wdata_i,
  output logic [dmw_pkg::PIX_W-1:0]   rdata_o
);

  logic [dmw_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [dmw_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/dmw_blend.sv
module dmw_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dmw_pkg::tag_t               tag_i,
  input  logic [dmw_pkg::PIX_W-1:0]   rdata_i,
  output logic                        room_o,
  dmw_out_if.source                   res_o
);

  dmw_pkg::tag_t tag_q;

  logic [dmw_pkg::ACC_W-1:0]  acc_q [dmw_pkg::CHANNELS];
  logic [dmw_pkg::ACC_W-1:0]  acc_d [dmw_pkg::CHANNELS];
  logic [dmw_pkg::PROD_W-1:0] prod  [dmw_pkg::CHANNELS];

  dmw_pkg::res_t                 fifo_q [dmw_pkg::RES_DEPTH];
  dmw_pkg::res_t                 res_d;
  logic [dmw_pkg::RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [dmw_pkg::RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                          push, pop, inflight;

  // Weighted sum, one neighbor per returned word.
  always_comb begin
    for (int c = 0; c < dmw_pkg::CHANNELS; c++) begin
      prod[c]  = dmw_pkg::PROD_W'(tag_q.wt * rdata_i[c*dmw_pkg::BYTE_W +: dmw_pkg::BYTE_W]);
      acc_d[c] = ((tag_q.k == '0) ? '0 : acc_q[c]) + dmw_pkg::ACC_W'(prod[c]);
    end
  end

  always_comb begin
    res_d.x    = tag_q.x;
    res_d.y    = tag_q.y;
    res_d.unch = 1'b0;
    case (tag_q.kind)
      dmw_pkg::OP_FAST: begin
        res_d.pixel = rdata_i;
      end
      dmw_pkg::OP_EXACT: begin
        res_d.pixel = {8'h00,
                       acc_d[2][dmw_pkg::BLEND_SHIFT +: dmw_pkg::BYTE_W],
                       acc_d[1][dmw_pkg::BLEND_SHIFT +: dmw_pkg::BYTE_W],
                       acc_d[0][dmw_pkg::BLEND_SHIFT +: dmw_pkg::BYTE_W]};
      end
      dmw_pkg::OP_BORDER: begin
        res_d.pixel = '0;
        res_d.unch  = 1'b1;
      end
      default: begin
        res_d.pixel = '0;
      end
    endcase
  end

  assign inflight = tag_q.vld && tag_q.last;
  assign push     = inflight;
  assign pop      = res_o.valid && res_o.ready;
  assign cnt_d    = cnt_q + dmw_pkg::RES_CNT_W'(push) - dmw_pkg::RES_CNT_W'(pop);
  // Room for one more result counts the one that lands this cycle.
  assign room_o   = (cnt_q + dmw_pkg::RES_CNT_W'(inflight))
                  < dmw_pkg::RES_CNT_W'(dmw_pkg::RES_DEPTH);

  assign res_o.valid     = (cnt_q != '0);
  assign res_o.out_pixel = fifo_q[rd_ptr_q].pixel;
  assign res_o.out_x     = fifo_q[rd_ptr_q].x;
  assign res_o.out_y     = fifo_q[rd_ptr_q].y;
  assign res_o.unchanged = fifo_q[rd_ptr_q].unch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      tag_q <= tag_i;
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.vld && (tag_q.kind == dmw_pkg::OP_EXACT)) begin
      for (int c = 0; c < dmw_pkg::CHANNELS; c++) begin
        acc_q[c] <= acc_d[c];
      end
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

endmodule

FILE: design/displacement_map_warp.sv
// Displacement map warp. Load requests (func 0) write a 32-bit source pixel
// into a frame store of MAX_WIDTH x MAX_HEIGHT words; every entry must be
// loaded before a displace request reads it. A displace request (func 1)
// carries a position and its mask pixel; the grey value of the mask, scaled
// by the signed step_x and step_y registers in 1/256 pixel, moves the
// position, which is then clamped to the configured frame. In fast mode the
// stored pixel at the moved position comes back unchanged. In exact mode the
// block blends the four neighbors around the moved position with subpixel
// weights, and frame-border positions return zero with unchanged set. Every
// displace request gives exactly one result, in request order; loads give
// none. An exact-mode interior position reads its four neighbors one after
// another through the single store port; any other request needs at most
// one store access. A request that gives a result waits while the result
// queue is full. Configuration must be written through cfg_i only while the
// block is idle; the block does not enforce this, and cfg_i is always ready.
module displacement_map_warp #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dmw_cfg_if.sink    cfg_i,
  dmw_in_if.sink     req_i,
  dmw_out_if.source  res_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  // Configuration registers, to be written only while the block is idle; the block does not enforce this.
  logic [dmw_pkg::CFG_DATA_W-1:0]    fw_q, fh_q;
  logic signed [dmw_pkg::STEP_W-1:0] step_x_q, step_y_q;
  logic                              exact_q;
  logic [dmw_pkg::CRD_W-1:0]         wm1, hm1;

  // Front pipeline to sequencer.
  logic             op_valid, op_ready;
  dmw_pkg::op_t     op;
  logic [AddrW-1:0] op_addr [dmw_pkg::NEIGHBORS];

  // Sequencer: holds one decoded request and issues its store accesses.
  logic                         seq_v_q;
  dmw_pkg::op_t                 seq_op_q;
  logic [AddrW-1:0]             seq_addr_q [dmw_pkg::NEIGHBORS];
  logic [dmw_pkg::NB_IDX_W-1:0] seq_cnt_q;
  logic                         seq_last, seq_has_res, seq_go;

  dmw_pkg::tag_t                tag;
  logic                         mem_we, mem_re;
  logic [dmw_pkg::PIX_W-1:0]    mem_rdata;
  logic                         room;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= dmw_pkg::RST_FRAME_SIZE;
      fh_q     <= dmw_pkg::RST_FRAME_SIZE;
      step_x_q <= '0;
      step_y_q <= '0;
      exact_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dmw_pkg::REG_FRAME_WIDTH:  fw_q     <= cfg_i.data;
        dmw_pkg::REG_FRAME_HEIGHT: fh_q     <= cfg_i.data;
        dmw_pkg::REG_STEP_X:       step_x_q <= $signed(cfg_i.data[dmw_pkg::STEP_W-1:0]);
        dmw_pkg::REG_STEP_Y:       step_y_q <= $signed(cfg_i.data[dmw_pkg::STEP_W-1:0]);
        dmw_pkg::REG_EXACT_MODE:   exact_q  <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Last valid column and row; a size of zero acts as one and a size above
  // the store acts as the store size.
  always_comb begin
    if (32'(fw_q) > MAX_WIDTH) begin
      wm1 = dmw_pkg::CRD_W'(MAX_WIDTH - 1);
    end else if (fw_q == '0) begin
      wm1 = '0;
    end else begin
      wm1 = fw_q - 1'b1;
    end
    if (32'(fh_q) > MAX_HEIGHT) begin
      hm1 = dmw_pkg::CRD_W'(MAX_HEIGHT - 1);
    end else if (fh_q == '0) begin
      hm1 = '0;
    end else begin
      hm1 = fh_q - 1'b1;
    end
  end

  dmw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .wm1_i      (wm1),
    .hm1_i      (hm1),
    .step_x_i   (step_x_q),
    .step_y_i   (step_y_q),
    .exact_i    (exact_q),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op),
    .addr_o     (op_addr)
  );

  // Only an exact-mode interior request needs more than one store access.
  // The request that produces a result is held back until the result queue
  // is sure to have room for it. Since all store accesses go through this
  // one in-order port, a load is always written before any later read.
  always_comb begin
    seq_last    = (seq_op_q.kind != dmw_pkg::OP_EXACT)
               || (seq_cnt_q == dmw_pkg::NB_IDX_W'(dmw_pkg::NEIGHBORS - 1));
    seq_has_res = (seq_op_q.kind == dmw_pkg::OP_FAST)
               || (seq_op_q.kind == dmw_pkg::OP_EXACT)
               || (seq_op_q.kind == dmw_pkg::OP_BORDER);
    seq_go      = seq_v_q && (!(seq_last && seq_has_res) || room);
    op_ready    = !seq_v_q || (seq_go && seq_last);

    mem_we = seq_go && (seq_op_q.kind == dmw_pkg::OP_LOAD);
    mem_re = seq_go && ((seq_op_q.kind == dmw_pkg::OP_FAST)
                     || (seq_op_q.kind == dmw_pkg::OP_EXACT));

    tag.vld  = seq_go && seq_has_res;
    tag.last = seq_last;
    tag.kind = seq_op_q.kind;
    tag.k    = seq_cnt_q;
    tag.wt   = seq_op_q.wt[seq_cnt_q];
    tag.x    = seq_op_q.x;
    tag.y    = seq_op_q.y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_v_q   <= 1'b0;
      seq_cnt_q <= '0;
    end else if (op_ready) begin
      seq_v_q   <= op_valid;
      seq_cnt_q <= '0;
    end else if (seq_go) begin
      seq_cnt_q <= seq_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_ready && op_valid) begin
      seq_op_q   <= op;
      seq_addr_q <= op_addr;
    end
  end

  dmw_frame_mem #(
    .DEPTH (Depth)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (seq_addr_q[seq_cnt_q]),
    .wdata_i (seq_op_q.data),
    .rdata_o (mem_rdata)
  );

  dmw_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .rdata_i (mem_rdata),
    .room_o  (room),
    .res_o   (res_o)
  );

endmodule

FILE: design/dmw_checker.sv
module dmw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [dmw_pkg::PIX_W-1:0]  res_pixel,
  input logic [dmw_pkg::POS_W-1:0]  res_x,
  input logic [dmw_pkg::POS_W-1:0]  res_y,
  input logic                       res_unchanged
);

  a_res_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_res_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_pixel) && $stable(res_x)
                                && $stable(res_y) && $stable(res_unchanged))
    else $error("result payload changed while stalled");

  a_unchanged_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_unchanged |-> (res_pixel == '0))
    else $error("unchanged result carries a nonzero pixel");

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid)
    else $error("result offered during reset");

endmodule

bind displacement_map_warp dmw_checker u_dmw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .res_pixel     (res_o.out_pixel),
  .res_x         (res_o.out_x),
  .res_y         (res_o.out_y),
  .res_unchanged (res_o.unchanged)
);

FILE: tb/tb_displacement_map_warp.sv
module tb_displacement_map_warp;
  import dmw_pkg::*;

  // The frame store is sized for the full 512 x 512 frame, the same as the block under test.
  localparam int MAX_W = 512;
  localparam int MAX_H = 512;

  // Loads give no result, so a quiet period of this length after the last result lets any load
  // still in flight finish before registers change.
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT_CYCLES = 500000;
  // After this many results, the receiver holds off long enough for the block to fill up.
  localparam int PRESSURE_AT     = 150;
  localparam int PRESSURE_CYCLES = 300;

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_DISPLACE = 1'b1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  dmw_cfg_if cfg_if ();
  dmw_in_if  req_if ();
  dmw_out_if res_if ();

  displacement_map_warp #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .res_o (res_if)
  );

  // ---------------------------------------------------------------------------------------------
  // Shadow of the block: its registers and the frame store entries loaded so far.
  // ---------------------------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0]     frame_w_raw = RST_FRAME_SIZE;
  logic [CFG_DATA_W-1:0]     frame_h_raw = RST_FRAME_SIZE;
  logic signed [STEP_W-1:0]  step_x_q    = '0;
  logic signed [STEP_W-1:0]  step_y_q    = '0;
  logic                      exact_q     = 1'b0;
  logic [PIX_W-1:0]          frame_copy [int];

  // Results that the block still owes, oldest first.
  res_t pending_results [$];

  int  mismatch_count      = 0;
  int  results_checked     = 0;
  int  loads_sent          = 0;
  int  displaces_sent      = 0;
  int  reg_writes          = 0;
  int  longest_input_stall = 0;
  int  cycle_count         = 0;
  // While set, neither side idles.
  bit  calm_stretch        = 1'b0;

  // Which source pixels one displace request reads, and with which weights.
  typedef struct {
    bit border;
    int nreads;
    int rx [NEIGHBORS];
    int ry [NEIGHBORS];
    int wt [NEIGHBORS];
  } warp_plan_t;

  // Widths and heights outside 1..max saturate into that range.
  function automatic int usable_dim(logic [CFG_DATA_W-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic int clamp_to(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // The grey value of the mask moves the position by step * grey in 1/256 pixel. The whole
  // pixel part is an arithmetic shift (a floor), the subpixel part the low byte in two's
  // complement. Exact mode leaves border positions alone and otherwise reads the pixel at the
  // moved position, its right neighbor and the two above them, all clamped to the frame.
  function automatic warp_plan_t plan_warp(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                           logic [PIX_W-1:0] mask);
    warp_plan_t p;
    int w, h, x, y, grey, dx, dy, sx, sy, xn, yn, xr, yu;
    w    = usable_dim(frame_w_raw, MAX_W);
    h    = usable_dim(frame_h_raw, MAX_H);
    x    = int'(px);
    y    = int'(py);
    grey = (int'(mask[7:0]) + int'(mask[15:8]) + int'(mask[23:16])) >> GREY_SHIFT;
    dx   = int'(step_x_q) * grey;
    dy   = int'(step_y_q) * grey;
    xn   = clamp_to(x + (dx >>> SUB_W), 0, w - 1);
    yn   = clamp_to(y + (dy >>> SUB_W), 0, h - 1);
    p.border = 1'b0;
    p.nreads = 1;
    p.rx     = '{xn, 0, 0, 0};
    p.ry     = '{yn, 0, 0, 0};
    p.wt     = '{0, 0, 0, 0};
    if (exact_q) begin
      if (x == 0 || y == 0 || x >= w - 1 || y >= h - 1) begin
        p.border = 1'b1;
        p.nreads = 0;
      end else begin
        sx = dx & 255;
        sy = dy & 255;
        xr = clamp_to(xn + 1, 0, w - 1);
        yu = clamp_to(yn - 1, 0, h - 1);
        p.nreads = NEIGHBORS;
        p.rx = '{xn, xr, xr, xn};
        p.ry = '{yn, yn, yu, yu};
        p.wt = '{int'(WT_FULL) - sx - sy, sx + int'(WT_HALF) - sy, sx + sy,
                 sy + int'(WT_HALF) - sx};
      end
    end
    return p;
  endfunction

  // Applies one accepted request to the shadow state. Returns 1 and the expected result for a
  // displace request, 0 for a load.
  function automatic bit apply_request(logic f, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                       logic [PIX_W-1:0] d, output res_t r);
    warp_plan_t       p;
    logic [PIX_W-1:0] nb [NEIGHBORS];
    int               acc;
    r = '0;
    if (f == FUNC_LOAD) begin
      if (int'(x) < MAX_W && int'(y) < MAX_H) frame_copy[int'(y) * MAX_W + int'(x)] = d;
      return 1'b0;
    end
    p = plan_warp(x, y, d);
    r.x = x;
    r.y = y;
    if (p.border) begin
      r.unch = 1'b1;
    end else begin
      for (int k = 0; k < p.nreads; k++) nb[k] = frame_copy[p.ry[k] * MAX_W + p.rx[k]];
      if (p.nreads == 1) begin
        r.pixel = nb[0];
      end else begin
        // Blended pixels keep only the three color bytes; the top byte stays zero.
        for (int c = 0; c < CHANNELS; c++) begin
          acc = 0;
          for (int k = 0; k < NEIGHBORS; k++) acc += p.wt[k] * int'(nb[k][BYTE_W*c +: BYTE_W]);
          r.pixel[BYTE_W*c +: BYTE_W] = BYTE_W'(acc >> BLEND_SHIFT);
        end
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result pixel %h at (%0d,%0d) with no request pending",
                                res_if.out_pixel, res_if.out_x, res_if.out_y));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (res_if.out_pixel !== want.pixel)
      report_mismatch($sformatf("out_pixel %h, expected %h at (%0d,%0d)",
                                res_if.out_pixel, want.pixel, want.x, want.y));
    if (res_if.out_x !== want.x)
      report_mismatch($sformatf("out_x %0d, expected %0d", res_if.out_x, want.x));
    if (res_if.out_y !== want.y)
      report_mismatch($sformatf("out_y %0d, expected %0d", res_if.out_y, want.y));
    if (res_if.unchanged !== want.unch)
      report_mismatch($sformatf("unchanged %b, expected %b at (%0d,%0d)",
                                res_if.unchanged, want.unch, want.x, want.y));
  endtask

  // Most gaps are short, a few are long, and none fall in a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The receiver stalls at random. Once, after enough results, it holds off for a long stretch
  // while the sender keeps offering requests, so the block has to fill up and stall its input.
  initial begin
    int stall_left;
    int hold_left;
    bit pressure_done;
    stall_left    = 0;
    hold_left     = 0;
    pressure_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) check_result();
      if (!pressure_done && results_checked >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // The run is bounded; hitting the limit means the block stopped answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles, %0d results still owed.",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Driving.
  // ---------------------------------------------------------------------------------------------

  // Offers one request after a random gap and returns at the edge where it is taken. Valid is
  // left high so that a request following right away does not lower and raise it in one step.
  task automatic send_request(input logic f, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [PIX_W-1:0] d);
    int gap;
    int waited;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= f;
    req_if.pos_x      <= x;
    req_if.pos_y      <= y;
    req_if.pixel_data <= d;
    waited = 0;
    @(posedge clk);
    while (!req_if.ready) begin
      waited++;
      @(posedge clk);
    end
    if (waited > longest_input_stall) longest_input_stall = waited;
  endtask

  // Sends a request and records what it should give back. A result typed into the directed
  // table replaces the predicted one; the shadow state is updated either way.
  task automatic issue_request(input logic f, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic [PIX_W-1:0] d,
                               input bit use_typed = 1'b0,
                               input logic [PIX_W-1:0] typed_pixel = '0,
                               input logic typed_unch = 1'b0);
    res_t predicted;
    send_request(f, x, y, d);
    if (apply_request(f, x, y, d, predicted)) begin
      displaces_sent++;
      if (use_typed) begin
        predicted.pixel = typed_pixel;
        predicted.unch  = typed_unch;
      end
      pending_results.push_back(predicted);
    end else begin
      loads_sent++;
    end
  endtask

  // Raises the register write request and waits for it to be taken. The caller lowers valid
  // once no further write follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    reg_writes++;
    case (idx)
      REG_FRAME_WIDTH:  frame_w_raw = val;
      REG_FRAME_HEIGHT: frame_h_raw = val;
      REG_STEP_X:       step_x_q    = val[STEP_W-1:0];
      REG_STEP_Y:       step_y_q    = val[STEP_W-1:0];
      REG_EXACT_MODE:   exact_q     = val[0];
      default: ;
    endcase
  endtask

  // Registers change only while the block is idle: every owed result is in, and loads that
  // give no result have had time to land in the store.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Directed part. Results are typed in where they follow directly from the stored pixels:
  // zero steps, zero grey, a clamped move, saturated frame sizes and the exact-mode border.
  // Blended pixels are left to the predictor. Every read position is loaded beforehand.
  // ---------------------------------------------------------------------------------------------
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  func;
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
    logic [PIX_W-1:0]      data;
    bit                    typed;
    logic [PIX_W-1:0]      want_pixel;
    logic                  want_unch;
  } dir_row_t;

  localparam int DIR_ROWS = 32;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // Corners of the store and the pixels that the moved positions below will land on.
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd0,   9'd0,   32'hFFFF_FFFF, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd511, 9'd511, 32'hA5A5_5A5A, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd1,   9'd1,   32'h1234_5678, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd191, 9'd0,   32'h6B3D_91E4, 0, '0, 0},
    // Reset steps are zero, so fast mode returns the stored pixel in place, top byte included.
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd0,   9'd0,   32'h0000_0000, 1, 32'hFFFF_FFFF, 0},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd511, 9'd511, 32'hFFFF_FFFF, 1, 32'hA5A5_5A5A, 0},
    // Largest steps with the largest grey: +190 columns, and -191 rows clamped to row 0.
    '{ROW_REG,  REG_STEP_X, 10'h0FF, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_REG,  REG_STEP_Y, 10'h100, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd1,   9'd1,   32'hFFFF_FFFF, 1, 32'h6B3D_91E4, 0},
    // A zero width saturates to one column and an oversized height to the full store.
    '{ROW_REG,  REG_FRAME_WIDTH,  10'd0,   '0, '0, '0, '0, 0, '0, 0},
    '{ROW_REG,  REG_FRAME_HEIGHT, 10'h3FF, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd511, 9'd0,   32'hFF00_0000, 1, 32'hFFFF_FFFF, 0},
    // A 4 x 4 frame in exact mode: a position on each border side and one outside the frame.
    '{ROW_REG,  REG_FRAME_WIDTH,  10'd4, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_REG,  REG_FRAME_HEIGHT, 10'd4, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_REG,  REG_STEP_X,       10'd0, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_REG,  REG_STEP_Y,       10'd0, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_REG,  REG_EXACT_MODE,   10'd1, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd0,   9'd2,   32'h00FF_FFFF, 1, 32'h0, 1},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd3,   9'd1,   32'h0000_0000, 1, 32'h0, 1},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd1,   9'd3,   32'h8080_8080, 1, 32'h0, 1},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd2,   9'd0,   32'h0000_0001, 1, 32'h0, 1},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd300, 9'd400, 32'hFFFF_FFFF, 1, 32'h0, 1},
    // Neighbors of (1,1), then a blend with no subpixel offset and one with the largest.
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd2,   9'd1,   32'hFF00_FF00, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd2,   9'd0,   32'h8080_8080, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd1,   9'd0,   32'h7F7F_7F7F, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd1,   9'd1,   32'h0012_3456, 0, '0, 0},
    '{ROW_REG,  REG_STEP_X, 10'h0FF, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_REG,  REG_STEP_Y, 10'h0FF, '0, '0, '0, '0, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd1,   9'd1,   32'h0000_0004, 0, '0, 0},
    // A long move off the frame corner: both neighbor reads clamp back onto the edge.
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd3,   9'd3,   32'h0102_0304, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_LOAD,     9'd3,   9'd2,   32'hFEDC_BA98, 0, '0, 0},
    '{ROW_ITEM, '0, '0, FUNC_DISPLACE, 9'd2,   9'd2,   32'h00FF_FFFF, 0, '0, 0}
  };

  // ---------------------------------------------------------------------------------------------
  // Random part: a series of register settings, the extremes among them. Each phase writes
  // all five registers while idle and then sends a mix of loads and displace requests.
  // ---------------------------------------------------------------------------------------------
  typedef struct {
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] sx;
    logic [CFG_DATA_W-1:0] sy;
    logic                  exact;
    bit                    calm;
    int                    n;
  } phase_t;

  initial begin
    phase_t           phases [$];
    warp_plan_t       plan;
    dir_row_t         row;
    bit               prev_reg;
    int               w, h, sent;
    logic [POS_W-1:0] px, py;
    logic [PIX_W-1:0] mask;

    req_if.valid      <= 1'b0;
    req_if.func       <= FUNC_LOAD;
    req_if.pos_x      <= '0;
    req_if.pos_y      <= '0;
    req_if.pixel_data <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_FRAME_WIDTH;
    cfg_if.data       <= '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_reg = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        if (!prev_reg) wait_idle();
        write_reg(row.reg_idx, row.reg_val);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) cfg_if.valid <= 1'b0;
        issue_request(row.func, row.x, row.y, row.data, row.typed, row.want_pixel,
                      row.want_unch);
        prev_reg = 1'b0;
      end
    end

    phases.push_back('{10'd512, 10'd512, 10'h0FF, 10'h100, 1'b0, 1'b0, 110});
    phases.push_back('{10'd1, 10'd1, 10'($urandom), 10'($urandom), 1'b0, 1'b1, 50});
    phases.push_back('{10'd0, 10'h3FF, 10'($urandom), 10'($urandom), 1'b1, 1'b0, 50});
    phases.push_back('{10'd8, 10'd8, 10'($urandom), 10'($urandom), 1'b1, 1'b0, 130});
    phases.push_back('{10'd16, 10'd5, 10'h300, 10'h100, 1'b1, 1'b0, 110});
    phases.push_back('{10'd3, 10'd3, 10'h0FF, 10'h0FF, 1'b1, 1'b1, 70});
    phases.push_back('{10'($urandom_range(2, 48)), 10'($urandom_range(2, 48)),
                       10'($urandom), 10'($urandom), 1'($urandom), 1'b1, 130});
    phases.push_back('{10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)),
                       10'($urandom), 10'($urandom), 1'b0, 1'b0, 120});
    phases.push_back('{10'd512, 10'd512, 10'($urandom), 10'($urandom), 1'b1, 1'b0, 90});

    foreach (phases[p]) begin
      wait_idle();
      calm_stretch = 1'b0;
      write_reg(REG_FRAME_WIDTH, phases[p].w);
      write_reg(REG_FRAME_HEIGHT, phases[p].h);
      write_reg(REG_STEP_X, phases[p].sx);
      write_reg(REG_STEP_Y, phases[p].sy);
      write_reg(REG_EXACT_MODE, {{(CFG_DATA_W-1){1'b0}}, phases[p].exact});
      cfg_if.valid <= 1'b0;
      calm_stretch = phases[p].calm;
      w = usable_dim(frame_w_raw, MAX_W);
      h = usable_dim(frame_h_raw, MAX_H);

      sent = 0;
      while (sent < phases[p].n) begin
        if ($urandom_range(0, 99) < 22) begin
          // Plain load, mostly inside the frame so that later reads find fresh data.
          if ($urandom_range(0, 99) < 60) begin
            px = POS_W'($urandom_range(0, w - 1));
            py = POS_W'($urandom_range(0, h - 1));
          end else begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
          end
          issue_request(FUNC_LOAD, px, py, $urandom);
          sent++;
        end else begin
          if ($urandom_range(0, 99) < 85) begin
            px = POS_W'($urandom_range(0, w - 1));
            py = POS_W'($urandom_range(0, h - 1));
          end else begin
            px = POS_W'($urandom);
            py = POS_W'($urandom);
          end
          mask = $urandom;
          // Half the masks are dim, which keeps moves short and subpixel offsets varied.
          if ($urandom_range(0, 1) == 1) mask[23:0] = mask[23:0] & 24'h0F0F0F;
          // Every pixel that this request will read is loaded first if it never was.
          plan = plan_warp(px, py, mask);
          for (int k = 0; k < plan.nreads; k++) begin
            if (!frame_copy.exists(plan.ry[k] * MAX_W + plan.rx[k])) begin
              issue_request(FUNC_LOAD, POS_W'(plan.rx[k]), POS_W'(plan.ry[k]), $urandom);
              sent++;
            end
          end
          issue_request(FUNC_DISPLACE, px, py, mask);
          sent++;
        end
      end
    end

    calm_stretch = 1'b0;
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads and %0d displace requests over %0d register writes,",
             loads_sent, displaces_sent, reg_writes);
    $display("%0d results checked; longest input stall was %0d cycles.",
             results_checked, longest_input_stall);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
